>>> hdl/erfc_pkg.sv
// Package for the EMG rep counter and fatigue classifier.
// Types, sizes and register codes shared by every module; no dependencies.
package erfc_pkg;

  // History row depth and kept bits of the zero-crossing rate
  localparam int unsigned HIST_DEPTH = 5;
  localparam int unsigned ZCR_W      = 16;
  localparam int unsigned FILL_W     = $clog2(HIST_DEPTH + 1);
  localparam int unsigned NEED_W     = (FILL_W > 3) ? FILL_W : 3;
  localparam int unsigned PROD_W     = ZCR_W + 9;

  // Field widths fixed by the channel definitions
  localparam int unsigned ZCR_IN_W  = 16;
  localparam int unsigned BPM_W     = 10;
  localparam int unsigned REP_W     = 16;
  localparam int unsigned TICK_W    = 8;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 9;

  // Percent scale of the trend test
  localparam int unsigned DROP_SCALE = 100;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_ACTIVE  = 3'd0,
    CFG_MAX_ACTIVE  = 3'd1,
    CFG_COOLDOWN    = 3'd2,
    CFG_HR_MILD     = 3'd3,
    CFG_HR_MODERATE = 3'd4,
    CFG_ZCR_DROP    = 3'd5,
    CFG_TREND_MIN   = 3'd6,
    CFG_HR_MIN_REPS = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_ACTIVE = 2'd1,
    PH_COOL   = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    LVL_NONE     = 2'd0,
    LVL_MILD     = 2'd1,
    LVL_MODERATE = 2'd2,
    LVL_SEVERE   = 2'd3
  } level_e;

  // Configuration register set
  typedef struct packed {
    logic [7:0] min_active_ticks;
    logic [7:0] max_active_ticks;
    logic [7:0] cooldown_ticks;
    logic [8:0] hr_mild_bpm;
    logic [8:0] hr_moderate_bpm;
    logic [6:0] zcr_drop_percent;
    logic [2:0] trend_min_reps;
    logic [7:0] hr_min_reps;
  } cfg_t;

  // Sequencer to history chain and scorer
  typedef struct packed {
    logic              push;
    logic [FILL_W-1:0] fill_d;
    logic [REP_W-1:0]  rep_d;
  } hist_ctl_t;

endpackage

>>> hdl/erfc_if.sv
// Channel interfaces of the EMG rep counter: tick input, result output and
// configuration write. Uses erfc_pkg for field widths.
interface erfc_in_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  window_ready;
  logic                                  emg_active;
  logic                                  emg_fatigue_flag;
  logic [erfc_pkg::ZCR_IN_W-1:0]         zero_cross_rate;
  logic signed [erfc_pkg::BPM_W-1:0]     heart_bpm;

  modport source (output valid, window_ready, emg_active, emg_fatigue_flag,
                  zero_cross_rate, heart_bpm, input ready);
  modport sink   (input valid, window_ready, emg_active, emg_fatigue_flag,
                  zero_cross_rate, heart_bpm, output ready);
endinterface

interface erfc_out_if;
  logic                          valid;
  logic                          ready;
  logic [erfc_pkg::REP_W-1:0]    rep_total;
  logic                          rep_pulse;
  logic [1:0]                    strain_level;

  modport source (output valid, rep_total, rep_pulse, strain_level, input ready);
  modport sink   (input valid, rep_total, rep_pulse, strain_level, output ready);
endinterface

interface erfc_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [erfc_pkg::CFG_IDX_W-1:0]    index;
  logic [erfc_pkg::CFG_DAT_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> hdl/erfc_cfg_regs.sv
// Configuration register file of the EMG rep counter.
// Uses erfc_pkg (cfg_t, register codes) and erfc_cfg_if.
module erfc_cfg_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  erfc_cfg_if.sink          cfg_i,
  output erfc_pkg::cfg_t    cfg_o
);

  erfc_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;

  // Decode one write request
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (erfc_pkg::cfg_idx_e'(cfg_i.index))
        erfc_pkg::CFG_MIN_ACTIVE:  cfg_d.min_active_ticks = cfg_i.data[7:0];
        erfc_pkg::CFG_MAX_ACTIVE:  cfg_d.max_active_ticks = cfg_i.data[7:0];
        erfc_pkg::CFG_COOLDOWN:    cfg_d.cooldown_ticks   = cfg_i.data[7:0];
        erfc_pkg::CFG_HR_MILD:     cfg_d.hr_mild_bpm      = cfg_i.data[8:0];
        erfc_pkg::CFG_HR_MODERATE: cfg_d.hr_moderate_bpm  = cfg_i.data[8:0];
        erfc_pkg::CFG_ZCR_DROP:    cfg_d.zcr_drop_percent = cfg_i.data[6:0];
        erfc_pkg::CFG_TREND_MIN:   cfg_d.trend_min_reps   = cfg_i.data[2:0];
        erfc_pkg::CFG_HR_MIN_REPS: cfg_d.hr_min_reps      = cfg_i.data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_active_ticks <= 8'd3;
      cfg_q.max_active_ticks <= 8'd30;
      cfg_q.cooldown_ticks   <= 8'd5;
      cfg_q.hr_mild_bpm      <= 9'd120;
      cfg_q.hr_moderate_bpm  <= 9'd150;
      cfg_q.zcr_drop_percent <= 7'd25;
      cfg_q.trend_min_reps   <= 3'd3;
      cfg_q.hr_min_reps      <= 8'd2;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> hdl/erfc_rep_fsm.sv
// Repetition sequencer: idle/active/cooldown phase, tick counter, history
// fill count and rep counter. Uses erfc_pkg.
module erfc_rep_fsm (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  logic                  emg_active_i,
  input  erfc_pkg::cfg_t        cfg_i,
  output erfc_pkg::hist_ctl_t   ctl_o
);

  erfc_pkg::phase_e                 phase_q, phase_d;
  logic [erfc_pkg::TICK_W-1:0]      tick_q, tick_d, tick_inc;
  logic [erfc_pkg::FILL_W-1:0]      fill_q, fill_d;
  logic [erfc_pkg::REP_W-1:0]       rep_q, rep_d;
  logic                             release_ok, timeout;

  // Saturating tick count and phase thresholds
  assign tick_inc   = (tick_q == '1) ? tick_q : tick_q + 1'b1;
  assign timeout    = (tick_inc >= cfg_i.max_active_ticks);
  assign release_ok = (tick_inc >= cfg_i.min_active_ticks);

  // Next phase and tick count
  always_comb begin
    phase_d = phase_q;
    tick_d  = tick_q;
    if (step_i) begin
      tick_d = tick_inc;
      case (phase_q)
        erfc_pkg::PH_ACTIVE: begin
          if (timeout) begin
            phase_d = erfc_pkg::PH_IDLE;
            tick_d  = '0;
          end else if (!emg_active_i) begin
            phase_d = release_ok ? erfc_pkg::PH_COOL : erfc_pkg::PH_IDLE;
            tick_d  = '0;
          end
        end
        erfc_pkg::PH_COOL: begin
          if (tick_inc >= cfg_i.cooldown_ticks) begin
            phase_d = erfc_pkg::PH_IDLE;
            tick_d  = '0;
          end
        end
        default: begin
          phase_d = erfc_pkg::PH_IDLE;
          if (emg_active_i) begin
            phase_d = erfc_pkg::PH_ACTIVE;
            tick_d  = '0;
          end
        end
      endcase
    end
  end

  // History control and rep counter
  always_comb begin
    ctl_o.push = 1'b0;
    fill_d     = fill_q;
    rep_d      = rep_q;
    if (step_i && (phase_q == erfc_pkg::PH_ACTIVE)) begin
      if (timeout) begin
        fill_d = '0;
      end else if (!emg_active_i && release_ok) begin
        ctl_o.push = 1'b1;
        rep_d      = rep_q + 1'b1;
        if (fill_q != erfc_pkg::FILL_W'(erfc_pkg::HIST_DEPTH)) begin
          fill_d = fill_q + 1'b1;
        end
      end
    end
    ctl_o.fill_d = fill_d;
    ctl_o.rep_d  = rep_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= erfc_pkg::PH_IDLE;
      tick_q  <= '0;
      fill_q  <= '0;
      rep_q   <= '0;
    end else begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      fill_q  <= fill_d;
      rep_q   <= rep_d;
    end
  end

endmodule

>>> hdl/erfc_hist_cell.sv
// One history cell: holds a zero-crossing rate, shifts it to the deeper
// neighbor on a push and forwards the oldest valid rate. Uses erfc_pkg.
module erfc_hist_cell (
  input  logic                          clk_i,
  input  logic                          push_i,
  input  logic [erfc_pkg::FILL_W-1:0]   pos_i,
  input  logic [erfc_pkg::FILL_W-1:0]   fill_d_i,
  input  logic [erfc_pkg::ZCR_W-1:0]    shift_i,
  output logic [erfc_pkg::ZCR_W-1:0]    shift_o,
  output logic [erfc_pkg::ZCR_W-1:0]    data_d_o,
  input  logic [erfc_pkg::ZCR_W-1:0]    oldest_i,
  output logic [erfc_pkg::ZCR_W-1:0]    oldest_o
);

  logic [erfc_pkg::ZCR_W-1:0] data_q, data_d;

  assign data_d = push_i ? shift_i : data_q;

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  // This cell is the oldest entry once the update lands
  assign oldest_o = (pos_i + 1'b1 == fill_d_i) ? data_d : oldest_i;
  assign shift_o  = data_q;
  assign data_d_o = data_d;

endmodule

>>> hdl/erfc_score.sv
// Fatigue scorer: EMG flag/trend score plus heart-rate band score (muted below the
// rep threshold when the EMG score is zero), clamped to severe. Uses erfc_pkg.
module erfc_score (
  input  erfc_pkg::cfg_t                    cfg_i,
  input  erfc_pkg::hist_ctl_t               ctl_i,
  input  logic                              flag_i,
  input  logic signed [erfc_pkg::BPM_W-1:0] bpm_i,
  input  logic [erfc_pkg::ZCR_W-1:0]        newest_i,
  input  logic [erfc_pkg::ZCR_W-1:0]        oldest_i,
  output logic [1:0]                        level_o
);

  localparam int unsigned PW = erfc_pkg::PROD_W;
  localparam logic signed [PW-1:0] SCALE = PW'(erfc_pkg::DROP_SCALE);

  logic [erfc_pkg::NEED_W-1:0]    need, fill_ext;
  logic                           trend_ok, hit;
  logic signed [PW-1:0]           old_s, new_s, x_s, thr_s;
  logic [1:0]                     es, hs;
  logic [2:0]                     total;

  // Entries required before the trend is trusted
  assign need     = (cfg_i.trend_min_reps == '0) ? erfc_pkg::NEED_W'(1)
                                                 : erfc_pkg::NEED_W'(cfg_i.trend_min_reps);
  assign fill_ext = erfc_pkg::NEED_W'(ctl_i.fill_d);
  assign trend_ok = (fill_ext >= need) && (oldest_i != '0);

  // Cross-multiplied percent drop test
  assign old_s = $signed(PW'(oldest_i));
  assign new_s = $signed(PW'(newest_i));
  assign x_s   = (old_s - new_s) * SCALE;
  assign thr_s = (cfg_i.zcr_drop_percent == '0) ? -old_s
                                                : $signed(PW'(cfg_i.zcr_drop_percent)) * old_s;
  assign hit   = (cfg_i.zcr_drop_percent == '0) ? (x_s > thr_s) : (x_s >= thr_s);

  assign es = flag_i ? 2'd2 : ((trend_ok && hit) ? 2'd1 : 2'd0);

  // Heart-rate band, muted while few reps are counted and the EMG score is zero
  always_comb begin
    hs = 2'd0;
    if (!bpm_i[erfc_pkg::BPM_W-1]) begin
      if (bpm_i[8:0] >= cfg_i.hr_moderate_bpm) begin
        hs = 2'd2;
      end else if (bpm_i[8:0] >= cfg_i.hr_mild_bpm) begin
        hs = 2'd1;
      end
    end
    if ((es == 2'd0) && (ctl_i.rep_d < erfc_pkg::REP_W'(cfg_i.hr_min_reps))) begin
      hs = 2'd0;
    end
  end

  assign total   = {1'b0, es} + {1'b0, hs};
  assign level_o = total[2] ? erfc_pkg::LVL_SEVERE : total[1:0];

endmodule

>>> hdl/emg_rep_fatigue_classifier_unit.sv
// Top level of the EMG rep counter and fatigue classifier.
// Uses erfc_pkg, erfc_if, erfc_cfg_regs, erfc_rep_fsm, erfc_hist_cell, erfc_score.
//
//   port    dir   handshake      carries
//   in_i    sink  valid/ready    window_ready, emg_active, emg_fatigue_flag,
//                                zero_cross_rate, heart_bpm
//   out_o   src   valid/ready    rep_total, rep_pulse, strain_level
//   cfg_i   sink  valid/ready    index, data (ready always high)
//
// One tick request per cycle while out_o is not stalled; the result of a tick shows
// in the output register in the cycle after acceptance. It is scored on acceptance
// through the history cell row and the two constant-size trend test products.
// A stalled result does not block input while out_o.ready is high.
// Reset is asynchronous active low and needs no clearing pass.
module emg_rep_fatigue_classifier_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  erfc_in_if.sink    in_i,
  erfc_out_if.source out_o,
  erfc_cfg_if.sink   cfg_i
);

  localparam int unsigned D = erfc_pkg::HIST_DEPTH;

  erfc_pkg::cfg_t                 cfg;
  erfc_pkg::hist_ctl_t            ctl;
  logic                           accept, step;
  logic [1:0]                     level_d;
  logic [erfc_pkg::ZCR_W-1:0]     shift   [D+1];
  logic [erfc_pkg::ZCR_W-1:0]     data_d  [D];
  logic [erfc_pkg::ZCR_W-1:0]     oldest  [D+1];

  logic                           out_valid_q;
  logic [erfc_pkg::REP_W-1:0]     rep_total_q;
  logic                           pulse_q;
  logic [1:0]                     level_q;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign step       = accept && in_i.window_ready;

  erfc_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  erfc_rep_fsm u_fsm (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .emg_active_i (in_i.emg_active),
    .cfg_i        (cfg),
    .ctl_o        (ctl)
  );

  // History row: newest in cell 0, oldest selected along the row
  assign shift[0]  = in_i.zero_cross_rate[erfc_pkg::ZCR_W-1:0];
  assign oldest[D] = '0;

  for (genvar i = 0; i < D; i++) begin : g_cell
    erfc_hist_cell u_cell (
      .clk_i    (clk_i),
      .push_i   (ctl.push),
      .pos_i    (erfc_pkg::FILL_W'(i)),
      .fill_d_i (ctl.fill_d),
      .shift_i  (shift[i]),
      .shift_o  (shift[i+1]),
      .data_d_o (data_d[i]),
      .oldest_i (oldest[i+1]),
      .oldest_o (oldest[i])
    );
  end

  erfc_score u_score (
    .cfg_i    (cfg),
    .ctl_i    (ctl),
    .flag_i   (in_i.emg_fatigue_flag),
    .bpm_i    (in_i.heart_bpm),
    .newest_i (data_d[0]),
    .oldest_i (oldest[0]),
    .level_o  (level_d)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      level_q     <= erfc_pkg::LVL_NONE;
    end else begin
      if (accept) begin
        out_valid_q <= 1'b1;
        if (in_i.window_ready) begin
          level_q <= level_d;
        end
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rep_total_q <= ctl.rep_d;
      pulse_q     <= ctl.push;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.rep_total    = rep_total_q;
  assign out_o.rep_pulse    = pulse_q;
  assign out_o.strain_level = level_q;

endmodule

>>> hdl/erfc_checker.sv
// Port-level checker for the EMG rep counter, bound to the top level.
// Uses erfc_pkg for widths.
module erfc_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_i,
  input logic                         in_window_ready_i,
  input logic                         in_emg_active_i,
  input logic                         in_flag_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [erfc_pkg::REP_W-1:0]   out_rep_total_i,
  input logic                         out_rep_pulse_i,
  input logic [1:0]                   out_level_i
);

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_i;

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_rep_total_i)
      && $stable(out_rep_pulse_i) && $stable(out_level_i))
    else $error("stalled result changed");

  // Every accepted tick yields a result next cycle
  a_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_valid_i)
    else $error("accepted tick produced no result");

  // No rep on a held tick or while activity continues
  a_no_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (!in_window_ready_i || in_emg_active_i) |=> !out_rep_pulse_i)
    else $error("rep pulse without a release");

  // Hard fatigue flag gives at least moderate
  a_flag_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_window_ready_i && in_flag_i |=> out_level_i[1])
    else $error("fatigue flag not reflected in level");

endmodule

bind emg_rep_fatigue_classifier_unit erfc_checker u_erfc_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_i.valid),
  .in_ready_i        (in_i.ready),
  .in_window_ready_i (in_i.window_ready),
  .in_emg_active_i   (in_i.emg_active),
  .in_flag_i         (in_i.emg_fatigue_flag),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .out_rep_total_i   (out_o.rep_total),
  .out_rep_pulse_i   (out_o.rep_pulse),
  .out_level_i       (out_o.strain_level)
);
